// ----- src/pfse_pkg.sv -----
// ----------------------------------------------------------------------------
// pfse_pkg
// Shared types and constants for the Playfair stream encryptor: key square
// layout, the pair transfer between front and back, and letter codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pfse_pkg;

    // Letter codes, A = 0
    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;

    // Square geometry
    localparam int unsigned SQ_SIZE   = 5;
    localparam int unsigned CODE_W    = 5;
    localparam int unsigned ROW_W     = SQ_SIZE * CODE_W;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW4 = 3'd4;

    // Row r in element r, column 0 in bits 4:0 of a row
    typedef logic [SQ_SIZE-1:0][ROW_W-1:0] key_square_t;

    // MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC
    localparam key_square_t KEY_RESET = {
        25'd2149955, 25'd6848868, 25'd25942713, 25'd17283508, 25'd10755244
    };

    // One prepared pair waiting to be enciphered
    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              last;
    } pair_job_t;

endpackage

`default_nettype wire

// ----- src/pfse_front.sv -----
// ----------------------------------------------------------------------------
// pfse_front
// Accepts message bytes, filters and uppercases letters, applies the repeat
// rule and builds letter pairs, padding with X at message end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfse_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        char_in,
    input  wire logic              message_last,
    input  wire logic              q_full,
    output logic                   q_push,
    output pfse_pkg::pair_job_t    q_job
);
    import pfse_pkg::*;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    logic [CODE_W-1:0] held_letter_reg, held_letter_next;
    logic              held_valid_reg,  held_valid_next;
    logic [CODE_W-1:0] prior_letter_reg, prior_letter_next;
    logic              prior_valid_reg,  prior_valid_next;

    logic              accept;
    logic              is_upper;
    logic              is_lower;
    logic              is_letter;
    logic [CODE_W-1:0] raw_code;
    logic [CODE_W-1:0] prep_code;

    // Queue full holds off the source
    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    // Classify the byte
    assign is_upper  = (char_in >= ASCII_UPPER_A) && (char_in <= ASCII_UPPER_Z);
    assign is_lower  = (char_in >= ASCII_LOWER_A) && (char_in <= ASCII_LOWER_Z);
    assign is_letter = is_upper | is_lower;
    assign raw_code  = is_upper ? CODE_W'(char_in - ASCII_UPPER_A)
                                : CODE_W'(char_in - ASCII_LOWER_A);
    assign prep_code = (prior_valid_reg && (raw_code == prior_letter_reg)) ? LETTER_X
                                                                            : raw_code;

    // Pairing and padding
    always_comb
    begin
        held_letter_next  = held_letter_reg;
        held_valid_next   = held_valid_reg;
        prior_letter_next = prior_letter_reg;
        prior_valid_next  = prior_valid_reg;
        q_push            = 1'b0;
        q_job.first       = held_letter_reg;
        q_job.second      = LETTER_X;
        q_job.last        = message_last;

        if (accept)
        begin
            if (is_letter)
            begin
                prior_letter_next = prep_code;
                prior_valid_next  = 1'b1;
                if (held_valid_reg)
                begin
                    q_push          = 1'b1;
                    q_job.second    = prep_code;
                    held_valid_next = 1'b0;
                end
                else if (message_last)
                begin
                    // lone letter at message end: pad
                    q_push      = 1'b1;
                    q_job.first = prep_code;
                end
                else
                begin
                    held_letter_next = prep_code;
                    held_valid_next  = 1'b1;
                end
            end
            else if (message_last && held_valid_reg)
            begin
                q_push = 1'b1;
            end

            if (message_last)
            begin
                held_valid_next  = 1'b0;
                prior_valid_next = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg  <= '0;
            held_valid_reg   <= 1'b0;
            prior_letter_reg <= '0;
            prior_valid_reg  <= 1'b0;
        end
        else
        begin
            held_letter_reg  <= held_letter_next;
            held_valid_reg   <= held_valid_next;
            prior_letter_reg <= prior_letter_next;
            prior_valid_reg  <= prior_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pfse_queue.sv -----
// ----------------------------------------------------------------------------
// pfse_queue
// Short first-in first-out queue of letter pairs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfse_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire pfse_pkg::pair_job_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output pfse_pkg::pair_job_t      head_data
);
    import pfse_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pair_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/pfse_back.sv -----
// ----------------------------------------------------------------------------
// pfse_back
// Locates each pair in the key square, applies the Playfair rules and
// presents the two cipher letters one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfse_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pfse_pkg::key_square_t key,
    input  wire logic                  q_valid,
    input  wire pfse_pkg::pair_job_t   q_job,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [6:0]                 cipher_letter,
    output logic                       pair_end,
    output logic                       message_end
);
    import pfse_pkg::*;

    localparam logic [6:0] ASCII_A = 7'd65;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } loc_t;

    // First match in row-major order; J also matches I; miss gives 0,0
    function automatic loc_t locate(key_square_t sq, logic [CODE_W-1:0] code);
        loc_t              res;
        logic [CODE_W-1:0] v;
        res = '0;
        for (int i = SQ_SIZE - 1; i >= 0; i--)
        begin
            for (int j = SQ_SIZE - 1; j >= 0; j--)
            begin
                v = sq[i][j*CODE_W +: CODE_W];
                if ((v == code) || ((code == LETTER_J) && (v == LETTER_I)))
                begin
                    res.row = 3'(i);
                    res.col = 3'(j);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] get_cell(key_square_t sq, logic [2:0] r,
                                                   logic [2:0] c);
        logic [ROW_W-1:0]  row_bits;
        logic [CODE_W-1:0] res;
        row_bits = sq[r];
        case (c)
            3'd0:    res = row_bits[4:0];
            3'd1:    res = row_bits[9:5];
            3'd2:    res = row_bits[14:10];
            3'd3:    res = row_bits[19:15];
            3'd4:    res = row_bits[24:20];
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [2:0] wrap_inc(logic [2:0] p);
        return (p == 3'(SQ_SIZE - 1)) ? 3'd0 : p + 3'd1;
    endfunction

    // Location stage
    logic  pos_valid_reg;
    loc_t  pos_a_reg, pos_b_reg;
    logic  pos_last_reg;

    // Output stage: two letters, phase selects which is shown
    logic       out_valid_reg;
    logic       out_phase_reg;
    logic [6:0] out_x_reg, out_y_reg;
    logic       out_last_reg;

    logic              out_done;
    logic              out_free;
    logic              pos_adv;
    logic              pos_free;
    logic              same_row;
    logic              same_col;
    logic [CODE_W-1:0] code_x;
    logic [CODE_W-1:0] code_y;

    // Stage handshakes
    assign out_done = out_valid_reg & ~out_stall & out_phase_reg;
    assign out_free = ~out_valid_reg | out_done;
    assign pos_adv  = pos_valid_reg & out_free;
    assign pos_free = ~pos_valid_reg | pos_adv;
    assign q_pop    = q_valid & pos_free;

    // Playfair rules
    assign same_row = (pos_a_reg.row == pos_b_reg.row);
    assign same_col = (pos_a_reg.col == pos_b_reg.col);

    always_comb
    begin
        priority if (same_row)
        begin
            code_x = get_cell(key, pos_a_reg.row, wrap_inc(pos_a_reg.col));
            code_y = get_cell(key, pos_b_reg.row, wrap_inc(pos_b_reg.col));
        end
        else if (same_col)
        begin
            code_x = get_cell(key, wrap_inc(pos_a_reg.row), pos_a_reg.col);
            code_y = get_cell(key, wrap_inc(pos_b_reg.row), pos_b_reg.col);
        end
        else
        begin
            code_x = get_cell(key, pos_a_reg.row, pos_b_reg.col);
            code_y = get_cell(key, pos_b_reg.row, pos_a_reg.col);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_phase_reg <= 1'b0;
        end
        else
        begin
            if (pos_free)
            begin
                pos_valid_reg <= q_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= pos_valid_reg;
                out_phase_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_phase_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pos_a_reg    <= locate(key, q_job.first);
            pos_b_reg    <= locate(key, q_job.second);
            pos_last_reg <= q_job.last;
        end
        if (pos_adv)
        begin
            out_x_reg    <= ASCII_A + {2'b00, code_x};
            out_y_reg    <= ASCII_A + {2'b00, code_y};
            out_last_reg <= pos_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cipher_letter = out_phase_reg ? out_y_reg : out_x_reg;
    assign pair_end      = out_phase_reg;
    assign message_end   = out_phase_reg & out_last_reg;

endmodule

`default_nettype wire

// ----- src/playfair_stream_encrypt.sv -----
// ----------------------------------------------------------------------------
// playfair_stream_encrypt
// Playfair 5x5 stream encryptor: byte stream in, cipher letter stream out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the pair queue has room; a byte that
// completes a pair (or ends a message with a letter waiting) queues one pair,
// and every pair leaves as two letter transfers, the second directly behind
// the first unless the output stalls, so the sustained rate is set by the
// output port. A pair reaches the output through the queue, the key-square
// lookup registers and the output register, in that order. Key rows are
// written through the configuration port, which is always ready; write them
// only while no message is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_stream_encrypt #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pfse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfse_pkg::ROW_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        char_in,
    input  wire logic                              message_last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [6:0]                             cipher_letter,
    output logic                                   pair_end,
    output logic                                   message_end
);
    import pfse_pkg::*;

    key_square_t key_reg;
    logic        q_full;
    logic        q_push;
    pair_job_t   q_in_job;
    logic        q_valid;
    pair_job_t   q_head_job;
    logic        q_pop;

    // Key square registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_ROW0: key_reg[0] <= cfg_data;
                REG_KEY_ROW1: key_reg[1] <= cfg_data;
                REG_KEY_ROW2: key_reg[2] <= cfg_data;
                REG_KEY_ROW3: key_reg[3] <= cfg_data;
                REG_KEY_ROW4: key_reg[4] <= cfg_data;
                default:      key_reg    <= key_reg;
            endcase
        end
    end

    pfse_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .message_last (message_last),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_in_job)
    );

    pfse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head_job)
    );

    pfse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .key           (key_reg),
        .q_valid       (q_valid),
        .q_job         (q_head_job),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_letter (cipher_letter),
        .pair_end      (pair_end),
        .message_end   (message_end)
    );

endmodule

`default_nettype wire

// ----- src/pfse_checker.sv -----
// ----------------------------------------------------------------------------
// pfse_checker
// Port-level checks on the output stream of the Playfair encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

module pfse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] cipher_letter,
    input wire logic       pair_end,
    input wire logic       message_end
);

    // A stalled letter holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cipher_letter)
                                   && $stable(pair_end) && $stable(message_end))
    else $error("stalled output letter changed");

    // Second letter of a pair follows the first at once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !pair_end |=> out_valid && pair_end)
    else $error("second letter of pair not presented next cycle");

    // Message end only on the closing letter of a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> pair_end)
    else $error("message end flagged on first letter of pair");

    // Letters come from 5-bit square codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cipher_letter >= 7'd65) && (cipher_letter <= 7'd96))
    else $error("cipher letter outside square code range");

endmodule

bind playfair_stream_encrypt pfse_checker u_pfse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cipher_letter (cipher_letter),
    .pair_end      (pair_end),
    .message_end   (message_end)
);

`default_nettype wire

// ----- tb/tb_playfair_stream_encrypt.sv -----
// ----------------------------------------------------------------------------
// tb_playfair_stream_encrypt
// Self-checking bench for the Playfair stream encryptor. A short table of
// hand-picked bytes comes first, then random messages under several key
// squares. Every accepted byte updates an in-bench copy of the cipher state,
// and every letter transfer is checked against the oldest predicted letter.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_playfair_stream_encrypt;
    timeunit 1ns;
    timeprecision 1ps;

    import pfse_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_WAIT      = 13;
    localparam int PIPE_SLACK    = 8;     // pipeline is three deep
    localparam int TAIL_CYCLES   = 32;
    localparam int STALL_LIMIT   = 1000;
    localparam int BYTE_TARGET   = 1300;
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0]  ASCII_UPPER_A = 8'h41;
    localparam logic [7:0]  ASCII_LOWER_A = 8'h61;
    localparam logic [15:0] NO_PAIR       = 16'h0000;

    // Key squares used by the random phases, in order
    typedef enum int {
        KEY_DEFAULT,
        KEY_SHUFFLED,
        KEY_ZEROS,
        KEY_ONES,
        KEY_LETTERS,
        KEY_RAW,
        KEY_RESTORE
    } key_kind_t;
    localparam int PHASES = 7;

    // One letter transfer on the output side
    typedef struct packed {
        logic [6:0] letter;
        logic       pair_end;
        logic       msg_end;
    } cipher_beat_t;

    // Directed byte; when typed is set, pair holds the two cipher letters
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [15:0] pair;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 27;

    // Expectations below are for the reset square MFHIK/UNOPQ/ZVWXY/ELARG/DSTBC
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        {8'h00, 1'b0, 1'b1, NO_PAIR},   // lowest byte, dropped
        {8'h40, 1'b0, 1'b1, NO_PAIR},   // just below 'A'
        {"H",   1'b0, 1'b1, NO_PAIR},
        {"I",   1'b0, 1'b1, "IK"},      // same row
        {"a",   1'b0, 1'b0, NO_PAIR},
        {8'h5B, 1'b0, 1'b1, NO_PAIR},   // just above 'Z'
        {"b",   1'b0, 1'b0, NO_PAIR},   // rectangle, lower case
        {"m",   1'b0, 1'b1, NO_PAIR},
        {"M",   1'b0, 1'b1, "IZ"},      // repeated letter becomes X
        {"u",   1'b0, 1'b0, NO_PAIR},
        {"E",   1'b0, 1'b0, NO_PAIR},   // same column
        {"D",   1'b0, 1'b1, NO_PAIR},
        {"z",   1'b0, 1'b1, "ME"},      // column wraps
        {"C",   1'b0, 1'b0, NO_PAIR},
        {"D",   1'b0, 1'b0, NO_PAIR},   // row wraps
        {"J",   1'b0, 1'b1, NO_PAIR},
        {"q",   1'b0, 1'b1, "KP"},      // J found at I's cell
        {"W",   1'b1, 1'b1, "XY"},      // lone letter padded at end
        {"b",   1'b0, 1'b1, NO_PAIR},
        {"b",   1'b1, 1'b1, "IR"},      // repeat on the closing byte
        {8'hFF, 1'b1, 1'b1, NO_PAIR},   // end with nothing waiting
        {"x",   1'b0, 1'b1, NO_PAIR},
        {8'h60, 1'b1, 1'b1, "YY"},      // pad X skips the repeat rule
        {"k",   1'b1, 1'b1, "IY"},
        {"g",   1'b0, 1'b0, NO_PAIR},
        {8'h7B, 1'b0, 1'b1, NO_PAIR},   // just above 'z'
        {"r",   1'b1, 1'b1, "EG"}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           char_in;
    logic                 message_last;
    logic                 out_valid;
    logic                 out_stall;
    logic [6:0]           cipher_letter;
    logic                 pair_end;
    logic                 message_end;

    // Cipher state mirror
    key_square_t  key_model;
    logic [4:0]   held_code;
    bit           held_ok;
    logic [4:0]   prev_code;
    bit           prev_ok;

    cipher_beat_t cipher_q[$];
    int           mismatches;
    int           bytes_in;
    bit           in_quiet;
    bit           out_quiet;

    playfair_stream_encrypt DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_in       (char_in),
        .message_last  (message_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_letter (cipher_letter),
        .pair_end      (pair_end),
        .message_end   (message_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Idle cycles before the next transfer; quiet stretches run flat out
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 47) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [6:0] square_letter(input int row, input int col);
        return 7'd65 + {2'b00, key_model[row % SQ_SIZE][(col % SQ_SIZE) * CODE_W +: CODE_W]};
    endfunction

    // First hit in row-major order; J also hits I; a miss lands on 0,0
    function automatic void locate_code(input logic [4:0] code, output int row,
                                        output int col);
        int         r;
        int         c;
        logic [4:0] v;
        bit         hit;
        row = 0;
        col = 0;
        hit = 1'b0;
        for (r = 0; r < SQ_SIZE; r++)
        begin
            for (c = 0; c < SQ_SIZE; c++)
            begin
                v = key_model[r][c * CODE_W +: CODE_W];
                if (!hit && (v == code || (code == LETTER_J && v == LETTER_I)))
                begin
                    row = r;
                    col = c;
                    hit = 1'b1;
                end
            end
        end
    endfunction

    function automatic void encipher_pair(input logic [4:0] a, input logic [4:0] b,
                                          input logic last, output cipher_beat_t first,
                                          output cipher_beat_t second);
        int r1;
        int c1;
        int r2;
        int c2;
        locate_code(a, r1, c1);
        locate_code(b, r2, c2);
        if (r1 == r2)
        begin
            first.letter  = square_letter(r1, c1 + 1);
            second.letter = square_letter(r2, c2 + 1);
        end
        else if (c1 == c2)
        begin
            first.letter  = square_letter(r1 + 1, c1);
            second.letter = square_letter(r2 + 1, c2);
        end
        else
        begin
            first.letter  = square_letter(r1, c2);
            second.letter = square_letter(r2, c1);
        end
        first.pair_end  = 1'b0;
        first.msg_end   = 1'b0;
        second.pair_end = 1'b1;
        second.msg_end  = last;
    endfunction

    // Advances the mirror by one byte; returns how many letters it yields
    function automatic int cipher_byte(input logic [7:0] ch, input logic last,
                                       output cipher_beat_t first,
                                       output cipher_beat_t second);
        logic [4:0] code;
        bit         letter;
        int         n;
        n      = 0;
        letter = 1'b0;
        code   = '0;
        first  = '0;
        second = '0;
        if (ch >= "A" && ch <= "Z")
        begin
            letter = 1'b1;
            code   = 5'(ch - "A");
        end
        else if (ch >= "a" && ch <= "z")
        begin
            letter = 1'b1;
            code   = 5'(ch - "a");
        end
        if (letter)
        begin
            if (prev_ok && code == prev_code)
                code = LETTER_X;
            prev_code = code;
            prev_ok   = 1'b1;
            if (held_ok)
            begin
                encipher_pair(held_code, code, last, first, second);
                held_ok = 1'b0;
                n       = 2;
            end
            else
            begin
                held_code = code;
                held_ok   = 1'b1;
            end
        end
        if (last)
        begin
            if (held_ok)
            begin
                encipher_pair(held_code, LETTER_X, 1'b1, first, second);
                n = 2;
            end
            held_ok = 1'b0;
            prev_ok = 1'b0;
        end
        return n;
    endfunction

    function automatic logic [CFG_IDX_W-1:0] key_row_reg(input int row);
        case (row)
            0:       return REG_KEY_ROW0;
            1:       return REG_KEY_ROW1;
            2:       return REG_KEY_ROW2;
            3:       return REG_KEY_ROW3;
            default: return REG_KEY_ROW4;
        endcase
    endfunction

    function automatic key_square_t key_for(input key_kind_t kind);
        key_square_t key;
        logic [4:0]  pool [SQ_SIZE * SQ_SIZE];
        logic [4:0]  t;
        logic [31:0] word;
        int          i;
        int          k;
        int          n;
        key = KEY_RESET;
        case (kind)
            KEY_SHUFFLED:
            begin
                // Proper square: 25 distinct letters, no J
                n = 0;
                for (i = 0; i < 26; i++)
                begin
                    if (5'(i) != LETTER_J)
                    begin
                        pool[n] = 5'(i);
                        n++;
                    end
                end
                for (i = SQ_SIZE * SQ_SIZE - 1; i > 0; i--)
                begin
                    k       = $urandom_range(0, i);
                    t       = pool[i];
                    pool[i] = pool[k];
                    pool[k] = t;
                end
                for (i = 0; i < SQ_SIZE * SQ_SIZE; i++)
                    key[i / SQ_SIZE][(i % SQ_SIZE) * CODE_W +: CODE_W] = pool[i];
            end
            KEY_ZEROS:
                key = '0;
            KEY_ONES:
                key = '1;
            KEY_LETTERS:
            begin
                // Letters with repeats: exercises first-match lookup and misses
                for (i = 0; i < SQ_SIZE * SQ_SIZE; i++)
                    key[i / SQ_SIZE][(i % SQ_SIZE) * CODE_W +: CODE_W] =
                        5'($urandom_range(0, 25));
            end
            KEY_RAW:
            begin
                for (i = 0; i < SQ_SIZE; i++)
                begin
                    word   = $urandom();
                    key[i] = word[ROW_W-1:0];
                end
            end
            default:
                key = KEY_RESET;
        endcase
        return key;
    endfunction

    // One byte transfer, then its predicted letters are queued
    task automatic send_byte(input logic [7:0] ch, input logic last, input logic typed,
                             input logic [15:0] pair);
        int           gap;
        int           n;
        cipher_beat_t first;
        cipher_beat_t second;
        gap = draw_wait(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_in      <= ch;
        message_last <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_in++;
        n = cipher_byte(ch, last, first, second);
        if (typed)
        begin
            if (pair != NO_PAIR)
            begin
                cipher_q.push_back({pair[14:8], 1'b0, 1'b0});
                cipher_q.push_back({pair[6:0], 1'b1, last});
            end
        end
        else if (n == 2)
        begin
            cipher_q.push_back(first);
            cipher_q.push_back(second);
        end
    endtask

    // Well-formed message: mostly letters, some repeats and stray bytes
    task automatic send_message(input int len);
        int         k;
        int         pick;
        logic [4:0] code;
        logic [7:0] ch;
        code = 5'($urandom_range(0, 25));
        for (k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                ch = 8'($urandom_range(0, 255));
            else
            begin
                if (pick > 2)
                    code = 5'($urandom_range(0, 25));
                ch = ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(code);
            end
            send_byte(ch, k == len - 1, 1'b0, NO_PAIR);
        end
    endtask

    // Raw bytes with end flags anywhere; always closed by an end flag
    task automatic send_garbage();
        int k;
        int len;
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)),
                      (k == len - 1) || ($urandom_range(0, 3) == 0), 1'b0, NO_PAIR);
    endtask

    // Hold the sender until every predicted letter has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cipher_q.size() != 0) @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic load_key(input key_square_t key);
        int r;
        for (r = 0; r < SQ_SIZE; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= key_row_reg(r);
            cfg_data  <= key[r];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            key_model[r] = key[r];
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin : stimulus
        int i;
        int p;
        int phase_end;
        int pause_at;
        bit paused;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_KEY_ROW0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        char_in      <= '0;
        message_last <= 1'b0;
        key_model  = KEY_RESET;
        held_code  = '0;
        held_ok    = 1'b0;
        prev_code  = '0;
        prev_ok    = 1'b0;
        mismatches = 0;
        bytes_in   = 0;
        in_quiet   = 1'b0;
        out_quiet  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].pair);

        bytes_in = 0;
        for (p = 0; p < PHASES; p++)
        begin
            if (p != int'(KEY_DEFAULT))
            begin
                drain_results();
                load_key(key_for(key_kind_t'(p)));
            end
            phase_end = bytes_in + BYTE_TARGET / PHASES;
            pause_at  = bytes_in + BYTE_TARGET / (2 * PHASES);
            paused    = 1'b0;
            while (bytes_in < phase_end)
            begin
                if (!paused && bytes_in >= pause_at)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) == 0)
                    send_garbage();
                else
                    send_message($urandom_range(1, 24));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && cipher_q.size() == 0)
            $display("PASS playfair_stream_encrypt");
        else
            $display("FAIL playfair_stream_encrypt");
        $finish;
    end

    // Letter receiver and checker
    initial
    begin : receiver
        int           gap;
        cipher_beat_t want;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_wait(out_quiet);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (cipher_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected letter %c (pair_end %0b, message_end %0b)",
                             cipher_letter, pair_end, message_end);
            end
            else
            begin
                want = cipher_q.pop_front();
                if (cipher_letter !== want.letter || pair_end !== want.pair_end ||
                    message_end !== want.msg_end)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("letter mismatch: expected %c/%0b/%0b, got %c/%0b/%0b",
                                 want.letter, want.pair_end, want.msg_end,
                                 cipher_letter, pair_end, message_end);
                end
            end
        end
    end

    // Watchdog: too long without any transfer on any port
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL playfair_stream_encrypt");
        $finish;
    end

endmodule

`default_nettype wire
